@@ design/clc_pkg.sv @@
// Shared types and constants for the cargo length codec.
// Used by clc_alu, clc_seq and cargo_length_codec_unit; no dependencies.
package clc_pkg;

    localparam int CODE_BITS_DEF = 7;   // default code width
    localparam int DATA_W        = 16;  // value / result width
    localparam int CFG_W         = 3;   // config register width
    localparam int ALU_W         = 28;  // (2^8 << 19) still fits for decode
    localparam int SHAMT_W       = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic KIND_ENCODE = 1'b0;

    localparam logic CFG_EXP_BITS = 1'b0;
    localparam logic CFG_MAN_BITS = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SHL,
        ALU_SHR
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_E_BYTES,
        S_E_LOOP,
        S_E_BACK,
        S_E_REST,
        S_E_ROUND,
        S_E_SHIFT,
        S_D_SUM,
        S_D_SHL,
        S_D_SUB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] result;
        logic [1:0]        status;
    } t_done;

endpackage

@@ design/clc_alu.sv @@
// Shared add / subtract / shift unit of the cargo length codec.
// Depends on clc_pkg.
module clc_alu (
    input  clc_pkg::t_alu_op           i_op,
    input  logic [clc_pkg::ALU_W-1:0] i_a,
    input  logic [clc_pkg::ALU_W-1:0] i_b,
    output logic [clc_pkg::ALU_W-1:0] o_y
);

    logic [clc_pkg::SHAMT_W-1:0] shamt;

    assign shamt = i_b[clc_pkg::SHAMT_W-1:0];

    always_comb begin
        case (i_op)
            clc_pkg::ALU_ADD: o_y = i_a + i_b;
            clc_pkg::ALU_SUB: o_y = i_a - i_b;
            clc_pkg::ALU_SHL: o_y = i_a << shamt;
            clc_pkg::ALU_SHR: o_y = i_a >> shamt;
            default:          o_y = '0;
        endcase
    end

endmodule

@@ design/clc_seq.sv @@
// Sequencer and working registers of the cargo length codec; drives the
// shared clc_alu one operation per cycle. Depends on clc_pkg, clc_alu.
module clc_seq #(
    parameter int CODE_BITS = clc_pkg::CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_kind,
    input  logic [clc_pkg::DATA_W-1:0]  i_value,
    input  logic [clc_pkg::CFG_W-1:0]   i_exp_bits,
    input  logic [clc_pkg::CFG_W-1:0]   i_man_bits,
    input  logic                        i_take,
    output logic                        o_busy,
    output clc_pkg::t_done              o_done
);

    clc_pkg::t_state r_state, n_state;
    logic [clc_pkg::ALU_W-1:0]  r_acc, n_acc;
    logic [clc_pkg::DATA_W-1:0] r_nbytes, n_nbytes;
    logic [clc_pkg::DATA_W-1:0] r_offset, n_offset;
    logic [clc_pkg::DATA_W-1:0] r_step, n_step;
    logic [4:0]                 r_e, n_e;
    logic [clc_pkg::DATA_W-1:0] r_res, n_res;
    logic [1:0]                 r_st, n_st;

    clc_pkg::t_alu_op           alu_op;
    logic [clc_pkg::ALU_W-1:0]  alu_a, alu_b, alu_y;

    logic                       split_ok;
    logic [clc_pkg::DATA_W-1:0] man_pow;
    logic [7:0]                 exp_lim;
    logic [clc_pkg::DATA_W-1:0] e_field;
    logic [clc_pkg::DATA_W-1:0] step2;
    logic [4:0]                 e_inc;

    clc_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign split_ok = ({1'b0, i_exp_bits} + {1'b0, i_man_bits}) == 4'(CODE_BITS);
    assign man_pow  = clc_pkg::DATA_W'(1) << i_man_bits;
    assign exp_lim  = 8'(1) << i_exp_bits;
    assign e_field  = (i_value >> i_man_bits)
                    & ((clc_pkg::DATA_W'(1) << i_exp_bits) - clc_pkg::DATA_W'(1));
    assign step2    = r_step << 1;
    assign e_inc    = r_e + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_nbytes <= n_nbytes;
        r_offset <= n_offset;
        r_step   <= n_step;
        r_e      <= n_e;
        r_res    <= n_res;
        r_st     <= n_st;
    end

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_nbytes = r_nbytes;
        n_offset = r_offset;
        n_step   = r_step;
        n_e      = r_e;
        n_res    = r_res;
        n_st     = r_st;
        alu_op   = clc_pkg::ALU_ADD;
        alu_a    = '0;
        alu_b    = '0;

        case (r_state)
            clc_pkg::S_IDLE: begin
                n_res = '0;
                if (i_valid) begin
                    n_acc = clc_pkg::ALU_W'(i_value);
                    n_e   = e_field[4:0];
                    if (i_kind == clc_pkg::KIND_ENCODE) begin
                        if (i_value == '0) begin
                            n_st    = clc_pkg::ST_ZERO;
                            n_state = clc_pkg::S_DONE;
                        end else if (!split_ok) begin
                            n_st    = clc_pkg::ST_SPLIT;
                            n_state = clc_pkg::S_DONE;
                        end else begin
                            n_state = clc_pkg::S_E_BYTES;
                        end
                    end else begin
                        if (!split_ok) begin
                            n_st    = clc_pkg::ST_SPLIT;
                            n_state = clc_pkg::S_DONE;
                        end else if ((i_value >> CODE_BITS) != '0 || e_field > 16) begin
                            n_st    = clc_pkg::ST_RANGE;
                            n_state = clc_pkg::S_DONE;
                        end else begin
                            n_state = clc_pkg::S_D_SUM;
                        end
                    end
                end
            end
            // bits to bytes, rounded up
            clc_pkg::S_E_BYTES: begin
                alu_op   = clc_pkg::ALU_ADD;
                alu_a    = r_acc;
                alu_b    = clc_pkg::ALU_W'(7);
                n_nbytes = alu_y[18:3];
                n_step   = man_pow;
                n_offset = man_pow;
                n_e      = '0;
                n_state  = clc_pkg::S_E_LOOP;
            end
            // exponent search: one exponent per cycle
            clc_pkg::S_E_LOOP: begin
                if (r_offset < r_nbytes) begin
                    alu_op   = clc_pkg::ALU_ADD;
                    alu_a    = clc_pkg::ALU_W'(r_offset);
                    alu_b    = clc_pkg::ALU_W'(step2);
                    n_step   = step2;
                    n_offset = alu_y[clc_pkg::DATA_W-1:0];
                    n_e      = e_inc;
                    if (8'(e_inc) >= exp_lim) begin
                        n_st    = clc_pkg::ST_RANGE;
                        n_state = clc_pkg::S_DONE;
                    end
                end else begin
                    n_state = clc_pkg::S_E_BACK;
                end
            end
            clc_pkg::S_E_BACK: begin
                alu_op   = clc_pkg::ALU_SUB;
                alu_a    = clc_pkg::ALU_W'(r_offset);
                alu_b    = clc_pkg::ALU_W'(r_step);
                n_offset = alu_y[clc_pkg::DATA_W-1:0];
                n_state  = clc_pkg::S_E_REST;
            end
            clc_pkg::S_E_REST: begin
                alu_op  = clc_pkg::ALU_SUB;
                alu_a   = clc_pkg::ALU_W'(r_nbytes);
                alu_b   = clc_pkg::ALU_W'(r_offset);
                n_acc   = alu_y;
                n_state = clc_pkg::S_E_ROUND;
            end
            clc_pkg::S_E_ROUND: begin
                alu_op  = clc_pkg::ALU_ADD;
                alu_a   = r_acc;
                alu_b   = (clc_pkg::ALU_W'(1) << r_e) - clc_pkg::ALU_W'(1);
                n_acc   = alu_y;
                n_state = clc_pkg::S_E_SHIFT;
            end
            // ceil(rest / 2^e); the mantissa stored is that minus one
            clc_pkg::S_E_SHIFT: begin
                alu_op  = clc_pkg::ALU_SHR;
                alu_a   = r_acc;
                alu_b   = clc_pkg::ALU_W'(r_e);
                n_state = clc_pkg::S_DONE;
                if (alu_y > clc_pkg::ALU_W'(man_pow)) begin
                    n_st = clc_pkg::ST_RANGE;
                end else begin
                    n_st  = clc_pkg::ST_OK;
                    n_res = (clc_pkg::DATA_W'(r_e) << i_man_bits)
                          | (alu_y[clc_pkg::DATA_W-1:0] - clc_pkg::DATA_W'(1));
                end
            end
            // decode: bits = ((x + 1 + 2^m) << (e + 3)) - (2^m << 3)
            clc_pkg::S_D_SUM: begin
                alu_op  = clc_pkg::ALU_ADD;
                alu_a   = clc_pkg::ALU_W'(r_acc[clc_pkg::DATA_W-1:0]
                                          & (man_pow - clc_pkg::DATA_W'(1)));
                alu_b   = clc_pkg::ALU_W'(man_pow) + clc_pkg::ALU_W'(1);
                n_acc   = alu_y;
                n_state = clc_pkg::S_D_SHL;
            end
            clc_pkg::S_D_SHL: begin
                alu_op  = clc_pkg::ALU_SHL;
                alu_a   = r_acc;
                alu_b   = clc_pkg::ALU_W'(r_e) + clc_pkg::ALU_W'(3);
                n_acc   = alu_y;
                n_state = clc_pkg::S_D_SUB;
            end
            clc_pkg::S_D_SUB: begin
                alu_op  = clc_pkg::ALU_SUB;
                alu_a   = r_acc;
                alu_b   = clc_pkg::ALU_W'(man_pow) << 3;
                n_state = clc_pkg::S_DONE;
                if (alu_y[clc_pkg::ALU_W-1:clc_pkg::DATA_W] != '0) begin
                    n_st = clc_pkg::ST_RANGE;
                end else begin
                    n_st  = clc_pkg::ST_OK;
                    n_res = alu_y[clc_pkg::DATA_W-1:0];
                end
            end
            clc_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = clc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy        = r_state != clc_pkg::S_IDLE;
    assign o_done.vld    = r_state == clc_pkg::S_DONE;
    assign o_done.result = r_res;
    assign o_done.status = r_st;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.vld && o_done.status != clc_pkg::ST_OK |-> o_done.result == '0)
        else $error("error status with nonzero result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_busy |=> o_busy)
        else $error("transaction accepted but sequencer stayed idle");

    a_offset_covers_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == clc_pkg::S_E_LOOP |-> r_offset >= r_step)
        else $error("cumulative offset below current step");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.vld && !i_take |=> o_done.vld && $stable(r_res) && $stable(r_st))
        else $error("finished result changed before hand-off");

endmodule

@@ design/cargo_length_codec_unit.sv @@
// Cargo length codec: bit count <-> exponent/mantissa length code.
// Usage:
//   Input channel (i_valid / o_stall, i_kind, i_value): a transaction is taken
//   when i_valid is high and o_stall is low. i_kind 0 encodes a bit count,
//   1 decodes a length code.
//   Output channel (o_valid / i_stall, o_result, o_status): one transaction per
//   input; o_result is 0 whenever o_status is not ok.
//   Config (i_cfg_we, i_cfg_index, i_cfg_data): index 0 exponent_bits, 1
//   mantissa_bits; write only while idle. The two must sum to CODE_BITS.
// Timing: one item at a time through a shared add/shift unit. An encode
//   turns bits into bytes, searches the exponent one step per cycle, steps
//   back, takes the rest, rounds and shifts; one that runs out of exponents
//   ends in the search. A decode sums, shifts and subtracts; an error caught
//   at the input skips all steps. o_stall is high until the result moves to
//   the output register; only then is a new item taken.
// Reset: synchronous, active low; exponent_bits = 3, mantissa_bits = 4,
//   no transaction pending.
// Stall: a finished result waits in the output register; the next item is
//   accepted and worked meanwhile and parks in the sequencer until the
//   output register frees up.
module cargo_length_codec_unit #(
    parameter int CODE_BITS = clc_pkg::CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [clc_pkg::DATA_W-1:0]  i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [clc_pkg::DATA_W-1:0]  o_result,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [clc_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [clc_pkg::CFG_W-1:0]  r_exp_bits;
    logic [clc_pkg::CFG_W-1:0]  r_man_bits;
    logic                       r_out_valid;
    logic [clc_pkg::DATA_W-1:0] r_out_result;
    logic [1:0]                 r_out_status;
    logic                       busy;
    logic                       take;
    clc_pkg::t_done             done;

    assign take = !r_out_valid || !i_stall;

    clc_seq #(
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .i_exp_bits (r_exp_bits),
        .i_man_bits (r_man_bits),
        .i_take     (take),
        .o_busy     (busy),
        .o_done     (done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_bits <= 3'd3;
            r_man_bits <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                clc_pkg::CFG_EXP_BITS: r_exp_bits <= i_cfg_data;
                clc_pkg::CFG_MAN_BITS: r_man_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= done.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && done.vld) begin
            r_out_result <= done.result;
            r_out_status <= done.status;
        end
    end

    assign o_stall  = busy;
    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;
    assign o_status = r_out_status;

endmodule
